@@ hdl/sit_pkg.sv @@
// Shared types and defaults for the segment intersection test.
// No dependencies; imported by sit_classify, segment_intersection_test and tb.
`default_nettype none

package sit_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Position of a point relative to a directed reference segment
  typedef enum logic [1:0] {
    CLS_RIGHT,
    CLS_LEFT,
    CLS_COL_IN,
    CLS_COL_OUT
  } cls_t;

endpackage

`default_nettype wire

@@ hdl/sit_classify.sv @@
// Three-stage classifier of point c against the segment from a to b.
// Stages: differences and box test, cross products, product compare.
// Depends on sit_pkg.
`default_nettype none

module sit_classify
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [COORD_WIDTH-1:0] a_x,
  input  wire logic signed [COORD_WIDTH-1:0] a_y,
  input  wire logic signed [COORD_WIDTH-1:0] b_x,
  input  wire logic signed [COORD_WIDTH-1:0] b_y,
  input  wire logic signed [COORD_WIDTH-1:0] c_x,
  input  wire logic signed [COORD_WIDTH-1:0] c_y,
  output cls_t                               cls
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // Stage 1: differences, degenerate flags, bounding box
  logic signed [DW-1:0] ux_nxt, uy_nxt, vx_nxt, vy_nxt;
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r;
  logic                 deg_nxt, same_nxt, in_box_nxt;
  logic                 deg_r, same_r, in_box_r;

  assign ux_nxt = DW'(b_x) - DW'(a_x);
  assign uy_nxt = DW'(b_y) - DW'(a_y);
  assign vx_nxt = DW'(c_x) - DW'(a_x);
  assign vy_nxt = DW'(c_y) - DW'(a_y);

  assign deg_nxt  = (a_x == b_x) && (a_y == b_y);
  assign same_nxt = (c_x == a_x) && (c_y == a_y);

  // c >= min(a, b) is c >= a or c >= b; likewise for the upper bound
  assign in_box_nxt = ((c_x >= a_x) || (c_x >= b_x)) && ((c_x <= a_x) || (c_x <= b_x)) &&
                      ((c_y >= a_y) || (c_y >= b_y)) && ((c_y <= a_y) || (c_y <= b_y));

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r     <= ux_nxt;
      uy_r     <= uy_nxt;
      vx_r     <= vx_nxt;
      vy_r     <= vy_nxt;
      deg_r    <= deg_nxt;
      same_r   <= same_nxt;
      in_box_r <= in_box_nxt;
    end
  end

  // Stage 2: the two cross product terms
  logic signed [PW-1:0] lhs_r, rhs_r;
  logic                 deg2_r, same2_r, in_box2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lhs_r     <= ux_r * vy_r;
      rhs_r     <= vx_r * uy_r;
      deg2_r    <= deg_r;
      same2_r   <= same_r;
      in_box2_r <= in_box_r;
    end
  end

  // Stage 3: compare and classify
  cls_t cls_nxt, cls_r;

  always_comb begin
    if (deg2_r) begin
      cls_nxt = same2_r ? CLS_COL_IN : CLS_RIGHT;
    end else if (lhs_r > rhs_r) begin
      cls_nxt = CLS_RIGHT;
    end else if (lhs_r < rhs_r) begin
      cls_nxt = CLS_LEFT;
    end else begin
      cls_nxt = in_box2_r ? CLS_COL_IN : CLS_COL_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls = cls_r;

endmodule

`default_nettype wire

@@ hdl/segment_intersection_test.sv @@
// Top level of the segment intersection test: four classifier pipelines
// and the final combine stage with the output register. Depends on sit_pkg, sit_classify.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  eight endpoint coordinates
//   out_     output     out_valid/out_stall out_intersects, out_endpoint_touch
//
// One transaction per cycle while no output stall holds the pipeline; each result passes
// through the three classifier stages and then the output register.
// A stall on the output while a result waits freezes the whole pipeline; bubbles are
// carried as cleared valid bits. Reset clears only the valid bits.
`default_nettype none

module segment_intersection_test
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_a_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_a_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_a_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_a_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_b_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_b_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_b_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_b_end_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_intersects,
  output logic                               out_endpoint_touch
);

  logic advance;
  logic v1_r, v2_r, v3_r, out_valid_r;
  cls_t r2s, r2e, r1s, r1e;

  // Hold everything while a finished result waits to be taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  sit_classify #(.COORD_WIDTH(COORD_WIDTH)) u_cls_bs (
    .clk(clk), .en(advance),
    .a_x(in_seg_a_start_x), .a_y(in_seg_a_start_y),
    .b_x(in_seg_a_end_x),   .b_y(in_seg_a_end_y),
    .c_x(in_seg_b_start_x), .c_y(in_seg_b_start_y),
    .cls(r2s)
  );

  sit_classify #(.COORD_WIDTH(COORD_WIDTH)) u_cls_be (
    .clk(clk), .en(advance),
    .a_x(in_seg_a_start_x), .a_y(in_seg_a_start_y),
    .b_x(in_seg_a_end_x),   .b_y(in_seg_a_end_y),
    .c_x(in_seg_b_end_x),   .c_y(in_seg_b_end_y),
    .cls(r2e)
  );

  sit_classify #(.COORD_WIDTH(COORD_WIDTH)) u_cls_as (
    .clk(clk), .en(advance),
    .a_x(in_seg_b_start_x), .a_y(in_seg_b_start_y),
    .b_x(in_seg_b_end_x),   .b_y(in_seg_b_end_y),
    .c_x(in_seg_a_start_x), .c_y(in_seg_a_start_y),
    .cls(r1s)
  );

  sit_classify #(.COORD_WIDTH(COORD_WIDTH)) u_cls_ae (
    .clk(clk), .en(advance),
    .a_x(in_seg_b_start_x), .a_y(in_seg_b_start_y),
    .b_x(in_seg_b_end_x),   .b_y(in_seg_b_end_y),
    .c_x(in_seg_a_end_x),   .c_y(in_seg_a_end_y),
    .cls(r1e)
  );

  // Combine the four classifications
  logic touch_nxt, any_out_nxt, inter_nxt;
  logic touch_r, inter_r;

  assign touch_nxt   = (r2s == CLS_COL_IN) || (r2e == CLS_COL_IN) ||
                       (r1s == CLS_COL_IN) || (r1e == CLS_COL_IN);
  assign any_out_nxt = (r2s == CLS_COL_OUT) || (r2e == CLS_COL_OUT) ||
                       (r1s == CLS_COL_OUT) || (r1e == CLS_COL_OUT);
  assign inter_nxt   = touch_nxt || (!any_out_nxt && (r2s != r2e) && (r1s != r1e));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      touch_r <= touch_nxt;
      inter_r <= inter_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_intersects     = inter_r;
  assign out_endpoint_touch = touch_r;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for segment_intersection_test: directed and random segment
// pairs, random handshake idling and one long output hold. Depends on sit_pkg and the RTL.
module tb
  import sit_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t a_sx, a_sy, a_ex, a_ey;
    coord_t b_sx, b_sy, b_ex, b_ey;
  } seg_pair_t;

  typedef struct packed {
    logic hit;
    logic touch;
  } verdict_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_seg_a_start_x = '0;
  coord_t in_seg_a_start_y = '0;
  coord_t in_seg_a_end_x = '0;
  coord_t in_seg_a_end_y = '0;
  coord_t in_seg_b_start_x = '0;
  coord_t in_seg_b_start_y = '0;
  coord_t in_seg_b_end_x = '0;
  coord_t in_seg_b_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   out_intersects;
  logic   out_endpoint_touch;

  verdict_t    expected_verdicts[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatches = 0;
  int          pairs_sent = 0;
  int          results_checked = 0;
  int          hits_seen = 0;
  int          touches_seen = 0;
  int          quiet_cycles = 0;
  int          hold_len = 0;
  logic        hold_on = 1'b0;
  event        hold_go;

  segment_intersection_test #(
    .COORD_WIDTH(CW)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_seg_a_start_x  (in_seg_a_start_x),
    .in_seg_a_start_y  (in_seg_a_start_y),
    .in_seg_a_end_x    (in_seg_a_end_x),
    .in_seg_a_end_y    (in_seg_a_end_y),
    .in_seg_b_start_x  (in_seg_b_start_x),
    .in_seg_b_start_y  (in_seg_b_start_y),
    .in_seg_b_end_x    (in_seg_b_end_x),
    .in_seg_b_end_y    (in_seg_b_end_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_intersects    (out_intersects),
    .out_endpoint_touch(out_endpoint_touch)
  );

  always #1 clk = ~clk;

  // Position of point c against the directed segment a->b, exact in 64 bits.
  function automatic cls_t place_point(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
    longint ux, uy, vx, vy, lhs, rhs;
    ux = bx - ax;
    uy = by - ay;
    vx = cx - ax;
    vy = cy - ay;
    if (ux == 0 && uy == 0) begin
      return (vx == 0 && vy == 0) ? CLS_COL_IN : CLS_RIGHT;
    end
    lhs = ux * vy;
    rhs = vx * uy;
    if (lhs > rhs) return CLS_RIGHT;
    if (lhs < rhs) return CLS_LEFT;
    if (cx >= (ax < bx ? ax : bx) && cx <= (ax > bx ? ax : bx) &&
        cy >= (ay < by ? ay : by) && cy <= (ay > by ? ay : by))
      return CLS_COL_IN;
    return CLS_COL_OUT;
  endfunction

  function automatic verdict_t judge_pair(seg_pair_t p);
    cls_t     bs_on_a, be_on_a, as_on_b, ae_on_b;
    verdict_t v;
    bs_on_a = place_point(p.a_sx, p.a_sy, p.a_ex, p.a_ey, p.b_sx, p.b_sy);
    be_on_a = place_point(p.a_sx, p.a_sy, p.a_ex, p.a_ey, p.b_ex, p.b_ey);
    as_on_b = place_point(p.b_sx, p.b_sy, p.b_ex, p.b_ey, p.a_sx, p.a_sy);
    ae_on_b = place_point(p.b_sx, p.b_sy, p.b_ex, p.b_ey, p.a_ex, p.a_ey);
    v.touch = (bs_on_a == CLS_COL_IN) || (be_on_a == CLS_COL_IN) ||
              (as_on_b == CLS_COL_IN) || (ae_on_b == CLS_COL_IN);
    if (v.touch)
      v.hit = 1'b1;
    else if (bs_on_a == CLS_COL_OUT || be_on_a == CLS_COL_OUT ||
             as_on_b == CLS_COL_OUT || ae_on_b == CLS_COL_OUT)
      v.hit = 1'b0;
    else
      v.hit = (bs_on_a != be_on_a) && (as_on_b != ae_on_b);
    return v;
  endfunction

  function automatic seg_pair_t pair_from(int a_sx, int a_sy, int a_ex, int a_ey,
                                          int b_sx, int b_sy, int b_ex, int b_ey);
    seg_pair_t p;
    p.a_sx = coord_t'(a_sx);
    p.a_sy = coord_t'(a_sy);
    p.a_ex = coord_t'(a_ex);
    p.a_ey = coord_t'(a_ey);
    p.b_sx = coord_t'(b_sx);
    p.b_sy = coord_t'(b_sy);
    p.b_ex = coord_t'(b_ex);
    p.b_ey = coord_t'(b_ey);
    return p;
  endfunction

  // Full-range coordinate, with the corner values turning up now and then.
  function automatic int wide_coord();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       return -32768;
        1:       return 32767;
        2:       return 0;
        default: return -1;
      endcase
    end
    return int'(coord_t'($urandom()));
  endfunction

  function automatic int span(int half);
    return int'($urandom_range(2 * half)) - half;
  endfunction

  function automatic seg_pair_t make_random_pair();
    int c[8];
    int px, py, dx, dy, i, kind, t;
    kind = $urandom_range(99);
    if (kind < 40) begin
      for (i = 0; i < 8; i++) c[i] = wide_coord();
    end else if (kind < 65) begin
      // tiny grid: plenty of colinear, coincident and touching cases
      for (i = 0; i < 8; i++) c[i] = span(4);
    end else if (kind < 80) begin
      px = span(1000);
      py = span(1000);
      dx = span(20);
      dy = span(20);
      // the parameter along the line is shared between x and y
      for (i = 0; i < 4; i++) begin
        t = span(20);
        c[2 * i] = px + t * dx;
        c[2 * i + 1] = py + t * dy;
      end
    end else if (kind < 90) begin
      px = span(10000);
      py = span(10000);
      dx = span(1000);
      dy = span(1000);
      c[0] = px;
      c[1] = py;
      c[2] = px + 2 * dx;
      c[3] = py + 2 * dy;
      case ($urandom_range(2))
        0: begin c[4] = px + dx; c[5] = py + dy; end
        1: begin c[4] = c[2];    c[5] = c[3];    end
        default: begin c[4] = px; c[5] = py;      end
      endcase
      c[6] = wide_coord();
      c[7] = wide_coord();
    end else begin
      c[0] = wide_coord();
      c[1] = wide_coord();
      c[2] = c[0];
      c[3] = c[1];
      for (i = 4; i < 8; i++) c[i] = wide_coord();
      if ($urandom_range(2) == 0) begin
        c[4] = c[0];
        c[5] = c[1];
        if ($urandom_range(1) == 0) begin
          c[6] = c[0];
          c[7] = c[1];
        end
      end
    end
    // swap segment roles and directions so every endpoint slot sees each case
    if ($urandom_range(1) == 0)
      return pair_from(c[4], c[5], c[6], c[7], c[0], c[1], c[2], c[3]);
    if ($urandom_range(1) == 0)
      return pair_from(c[2], c[3], c[0], c[1], c[6], c[7], c[4], c[5]);
    return pair_from(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task automatic send_pair(input seg_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_seg_a_start_x <= p.a_sx;
    in_seg_a_start_y <= p.a_sy;
    in_seg_a_end_x   <= p.a_ex;
    in_seg_a_end_y   <= p.a_ey;
    in_seg_b_start_x <= p.b_sx;
    in_seg_b_start_y <= p.b_sy;
    in_seg_b_end_x   <= p.b_ex;
    in_seg_b_end_y   <= p.b_ey;
    do @(posedge clk); while (in_stall);
    expected_verdicts.push_back(judge_pair(p));
    pairs_sent++;
  endtask

  // Check each result transaction against the oldest expected verdict.
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: result with nothing expected: intersects %0b touch %0b",
                   out_intersects, out_endpoint_touch);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_intersects !== want.hit || out_endpoint_touch !== want.touch) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: result %0d: intersects exp %0b got %0b, touch exp %0b got %0b",
                     results_checked, want.hit, out_intersects, want.touch,
                     out_endpoint_touch);
        end
        results_checked++;
        hits_seen    += out_intersects === 1'b1;
        touches_seen += out_endpoint_touch === 1'b1;
      end
    end
    out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  // Long output hold, counted here so the sender keeps offering meanwhile.
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (hold_len) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_crossings();
    send_pair(pair_from(-10, 0, 10, 0, 0, -10, 0, 10));
    send_pair(pair_from(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(pair_from(0, 0, 10, 0, 0, 5, 10, 5));
    send_pair(pair_from(0, 0, 10, 0, 20, -5, 20, 5));
    send_pair(pair_from(0, 0, 10, 0, 3, 1, 7, 9));
    send_pair(pair_from(0, 0, 10, 0, 5, 0, 5, 8));
    send_pair(pair_from(0, 0, 10, 0, 10, 0, 15, 7));
  endtask

  task automatic test_colinear();
    send_pair(pair_from(0, 0, 10, 0, 5, 0, 20, 0));
    send_pair(pair_from(0, 0, 5, 0, 10, 0, 20, 0));
    send_pair(pair_from(0, 0, 4, 4, 6, 6, 9, 9));
    send_pair(pair_from(0, 0, 20, 0, 5, 0, 10, 0));
    send_pair(pair_from(0, 0, 0, 10, 0, 10, 0, 30));
  endtask

  task automatic test_degenerate();
    send_pair(pair_from(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(pair_from(3, 3, 3, 3, 100, -4, 200, 9));
    send_pair(pair_from(7, -2, 7, -2, 7, -2, 7, -2));
    send_pair(pair_from(7, -2, 7, -2, 8, -2, 8, -2));
    send_pair(pair_from(0, 0, 9, 9, 20, 20, 20, 20));
  endtask

  task automatic test_extremes();
    send_pair(pair_from(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_from(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(pair_from(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pair_from(-32768, 32767, 32767, 32766, -32768, 32766, 32767, 32767));
    send_pair(pair_from(-32768, 0, 32767, 0, -32768, 1, 32767, 1));
    send_pair(pair_from(-32768, -32768, 32767, 32767, 32767, -32768, 32766, -32767));
  endtask

  task automatic test_random_pairs(int unsigned s_pct, int unsigned r_pct, int count);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (count) send_pair(make_random_pair());
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 80;
    ->hold_go;
    repeat (30) send_pair(make_random_pair());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_crossings();
    test_colinear();
    test_degenerate();
    test_extremes();
    test_random_pairs(17, 61, 650);
    test_random_pairs(61, 17, 650);
    test_random_pairs(0, 0, 650);
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d segment pairs checked, %0d intersecting, %0d with an endpoint touch",
             results_checked, hits_seen, touches_seen);
    $display("tb: covered three idling mixes, one 80-cycle output hold, %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
